// ----- hw/rtl/spf_pkg.sv -----
package spf_pkg;

    localparam int VAL_W     = 13;
    localparam int MAX_VALUE = 8191;
    localparam int FAC_W     = 7;
    localparam int TBL_DEPTH = (MAX_VALUE >> 1) + 1;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int SQ_W      = 2 * FAC_W;
    localparam int SLOTS     = 64;
    localparam int SLOT_AW   = $clog2(SLOTS);
    localparam int CNT_W     = SLOT_AW + 1;
    localparam int DIV_CW    = $clog2(VAL_W);

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [VAL_W-1:0] query_value;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0] divisor;
        logic             last;
        logic             error;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
        logic [VAL_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic              rd;
        logic [TBL_AW-1:0] addr;
    } t_look_req;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUILD,
        T_QUERY,
        T_RESP
    } t_top_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_P_SQ,
        S_P_TEST,
        S_P_CHK,
        S_M_TEST,
        S_M_CHK,
        S_DONE
    } t_sieve_state;

    typedef enum logic [3:0] {
        E_IDLE,
        E_CHECK,
        E_LOOK,
        E_DIV,
        E_DIV_WAIT,
        E_POW,
        E_APP_RD,
        E_APP_MUL,
        E_APP_WR,
        E_AFTER,
        E_EMIT_RD,
        E_EMIT
    } t_enum_state;

endpackage

// ----- hw/rtl/spf_sieve_divisor_enumerator_core.sv -----
// Smallest-prime-factor sieve and divisor lister. A build word clears the
// 4096-entry factor table and then sieves the odd numbers up to the
// configured limit, testing each odd candidate and marking the multiples of
// each prime found, at most one table access per cycle; a build answers with
// one word, divisor 0. A query word lists every divisor of its value, 1 first,
// with last set on the final one; for each factor tried it runs a division by
// the 13-step divider and generates the new divisors, and then it sends them.
// A query of zero, above the limit, or before a build (any limit write clears
// the built table) gives one word with error set. One word is worked on at a
// time; the input is not ready meanwhile.
module spf_sieve_divisor_enumerator_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  spf_pkg::t_in_word         i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output spf_pkg::t_out_word        o_out_word,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [spf_pkg::VAL_W-1:0] i_cfg_data
);
    import spf_pkg::*;

    t_top_state r_state;
    t_top_state n_state;

    logic [VAL_W-1:0] r_limit;
    logic             r_built;
    t_out_word        r_resp;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic             in_accept;
    logic             cfg_accept;
    logic             build_start;
    logic             enum_start;
    logic             query_bad;
    logic             can_load;
    logic             load_resp;
    logic             enum_res_ready;
    logic [VAL_W-1:0] eff_limit;

    t_look_req        look;
    logic [FAC_W-1:0] fac;
    logic             sieve_done;
    logic             enum_res_valid;
    t_out_word        enum_res_word;
    logic             enum_done;

    spf_sieve u_sieve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (build_start),
        .i_limit (eff_limit),
        .i_look  (look),
        .o_fac   (fac),
        .o_done  (sieve_done)
    );

    spf_enum u_enum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (enum_start),
        .i_value     (i_in_word.query_value),
        .o_look      (look),
        .i_fac       (fac),
        .o_res_valid (enum_res_valid),
        .o_res_word  (enum_res_word),
        .i_res_ready (enum_res_ready),
        .o_done      (enum_done)
    );

    always_comb begin
        eff_limit = (r_limit > VAL_W'(MAX_VALUE)) ? VAL_W'(MAX_VALUE) : r_limit;
        query_bad = !r_built || (i_in_word.query_value == '0)
                    || (i_in_word.query_value > eff_limit);
        can_load  = !r_out_valid || i_out_ready;
        cfg_accept = i_cfg_valid && o_cfg_ready;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (in_accept) begin
                    if (i_in_word.opcode == OP_BUILD) begin
                        n_state = T_BUILD;
                    end else begin
                        n_state = query_bad ? T_RESP : T_QUERY;
                    end
                end
            end
            T_BUILD: if (sieve_done) n_state = T_RESP;
            T_QUERY: if (enum_done) n_state = T_IDLE;
            T_RESP:  if (can_load) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == T_IDLE);
        in_accept      = i_in_valid && o_in_ready;
        build_start    = in_accept && (i_in_word.opcode == OP_BUILD);
        enum_start     = in_accept && (i_in_word.opcode == OP_QUERY) && !query_bad;
        load_resp      = (r_state == T_RESP) && can_load;
        enum_res_ready = (r_state == T_QUERY) && can_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_limit     <= VAL_W'(MAX_VALUE);
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_accept) begin
                r_limit <= i_cfg_data;
                r_built <= 1'b0;
            end else if (sieve_done) begin
                r_built <= 1'b1;
            end
            if (load_resp || (enum_res_valid && enum_res_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_resp <= '{divisor: '0, last: 1'b1, error: 1'b1};
        end else if (sieve_done) begin
            r_resp <= '{divisor: '0, last: 1'b1, error: 1'b0};
        end
        if (load_resp) begin
            r_out_word <= r_resp;
        end else if (enum_res_valid && enum_res_ready) begin
            r_out_word <= enum_res_word;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    // error word is always a lone word with divisor zero
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.error) |-> (o_out_word.last && o_out_word.divisor == '0))
        else $error("error word without last or with nonzero divisor");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("input ready right after accepting a word");

    a_cfg_clears_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_accept |=> !r_built)
        else $error("table still marked built after limit write");

    a_query_needs_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        enum_start |-> r_built)
        else $error("divisor listing started without a built table");
`endif

endmodule

// ----- hw/rtl/spf_div.sv -----
module spf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spf_pkg::t_div_req i_req,
    output spf_pkg::t_div_rsp o_rsp
);
    import spf_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [VAL_W-1:0]  r_acc;
    logic [VAL_W-1:0]  r_quo;
    logic [VAL_W-1:0]  r_dvs;

    logic [VAL_W:0] shifted;
    logic [VAL_W:0] diff;
    logic           take;

    // one restoring step per cycle
    always_comb begin
        shifted = {r_acc, r_quo[VAL_W-1]};
        take    = shifted >= {1'b0, r_dvs};
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_acc <= take ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
                r_quo <= {r_quo[VAL_W-2:0], take};
                r_cnt <= r_cnt + DIV_CW'(1);
                if (r_cnt == DIV_CW'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_acc;

endmodule

// ----- hw/rtl/spf_sieve.sv -----
module spf_sieve (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [spf_pkg::VAL_W-1:0]   i_limit,
    input  spf_pkg::t_look_req          i_look,
    output logic [spf_pkg::FAC_W-1:0]   o_fac,
    output logic                        o_done
);
    import spf_pkg::*;

    logic [FAC_W-1:0] mem [TBL_DEPTH];

    t_sieve_state r_state;
    t_sieve_state n_state;

    logic [TBL_AW-1:0] r_idx;
    logic [FAC_W-1:0]  r_p;
    logic [SQ_W-1:0]   r_sq;
    logic [SQ_W-1:0]   r_m;
    logic [FAC_W-1:0]  r_rd;

    logic              rd_en;
    logic [TBL_AW-1:0] rd_addr;
    logic              wr_en;
    logic [TBL_AW-1:0] wr_addr;
    logic [FAC_W-1:0]  wr_data;
    logic [SQ_W-1:0]   lim_x;

    assign lim_x = SQ_W'(i_limit);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_CLR;
            S_CLR:    if (r_idx == TBL_AW'(TBL_DEPTH - 1)) n_state = S_P_SQ;
            S_P_SQ:   n_state = S_P_TEST;
            S_P_TEST: n_state = (r_sq > lim_x) ? S_DONE : S_P_CHK;
            S_P_CHK:  n_state = (r_rd != '0) ? S_P_SQ : S_M_TEST;
            S_M_TEST: n_state = (r_m > lim_x) ? S_P_SQ : S_M_CHK;
            S_M_CHK:  n_state = S_M_TEST;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = i_look.addr;
        wr_en   = 1'b0;
        wr_addr = r_m[TBL_AW:1];
        wr_data = r_p;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                rd_en = i_look.rd;
            end
            S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = '0;
            end
            S_P_TEST: begin
                rd_en   = 1'b1;
                rd_addr = TBL_AW'(r_p[FAC_W-1:1]);
            end
            S_M_TEST: begin
                rd_en   = 1'b1;
                rd_addr = r_m[TBL_AW:1];
            end
            S_M_CHK: begin
                wr_en = (r_rd == '0);
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx <= '0;
                r_p   <= FAC_W'(3);
            end
            S_CLR: begin
                r_idx <= r_idx + TBL_AW'(1);
            end
            S_P_SQ: begin
                r_sq <= SQ_W'(r_p) * SQ_W'(r_p);
            end
            S_P_CHK: begin
                r_m <= r_sq;
                if (r_rd != '0) begin
                    r_p <= r_p + FAC_W'(2);
                end
            end
            S_M_TEST: begin
                if (r_m > lim_x) begin
                    r_p <= r_p + FAC_W'(2);
                end
            end
            S_M_CHK: begin
                r_m <= r_m + SQ_W'({r_p, 1'b0});
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_fac = r_rd;

endmodule

// ----- hw/rtl/spf_enum.sv -----
module spf_enum (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [spf_pkg::VAL_W-1:0]  i_value,
    output spf_pkg::t_look_req         o_look,
    input  logic [spf_pkg::FAC_W-1:0]  i_fac,
    output logic                       o_res_valid,
    output spf_pkg::t_out_word         o_res_word,
    input  logic                       i_res_ready,
    output logic                       o_done
);
    import spf_pkg::*;

    logic [VAL_W-1:0] mem [SLOTS];

    t_enum_state r_state;
    t_enum_state n_state;

    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_p;
    logic [VAL_W-1:0] r_power;
    logic [VAL_W-1:0] r_prod;
    logic [VAL_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_base;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_k;
    logic             r_first;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    logic [VAL_W-1:0]   wr_data;

    logic [VAL_W-1:0]   mul_a;
    logic [2*VAL_W-1:0] mul_full;
    logic [VAL_W-1:0]   mul_lo;
    logic               has_room;
    logic               div_accept;
    logic               is_last;
    logic [VAL_W-1:0]   look_p;
    logic [CNT_W-1:0]   i_inc;

    spf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        mul_a      = (r_state == E_POW) ? r_p : r_rd;
        mul_full   = mul_a * r_power;
        mul_lo     = mul_full[VAL_W-1:0];
        has_room   = (r_count < CNT_W'(SLOTS));
        div_accept = r_first || (div_rsp.rem == '0);
        is_last    = ((r_k + CNT_W'(1)) == r_count);
        look_p     = (i_fac < FAC_W'(2)) ? r_rem : VAL_W'(i_fac);
        i_inc      = r_i + CNT_W'(1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE:     if (i_start) n_state = E_CHECK;
            E_CHECK: begin
                if (r_rem > VAL_W'(1)) begin
                    n_state = r_rem[0] ? E_LOOK : E_DIV;
                end else begin
                    n_state = E_EMIT_RD;
                end
            end
            E_LOOK:     n_state = E_DIV;
            E_DIV:      n_state = E_DIV_WAIT;
            E_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = div_accept ? E_POW : E_CHECK;
                end
            end
            E_POW:      n_state = E_APP_RD;
            E_APP_RD:   n_state = E_APP_MUL;
            E_APP_MUL:  n_state = E_APP_WR;
            E_APP_WR:   n_state = (i_inc == r_base) ? E_AFTER : E_APP_RD;
            E_AFTER:    n_state = (r_rem > VAL_W'(1)) ? E_DIV : E_CHECK;
            E_EMIT_RD:  n_state = E_EMIT;
            E_EMIT: begin
                if (i_res_ready) begin
                    n_state = is_last ? E_IDLE : E_EMIT_RD;
                end
            end
            default:    n_state = E_IDLE;
        endcase
    end

    always_comb begin
        rd_en            = 1'b0;
        rd_addr          = r_i[SLOT_AW-1:0];
        wr_en            = 1'b0;
        wr_addr          = r_count[SLOT_AW-1:0];
        wr_data          = r_prod;
        o_look.rd        = 1'b0;
        o_look.addr      = r_rem[TBL_AW:1];
        div_req.start    = 1'b0;
        div_req.dividend = r_rem;
        div_req.divisor  = r_p;
        o_res_valid      = 1'b0;
        o_res_word       = '{divisor: r_rd, last: is_last, error: 1'b0};
        o_done           = 1'b0;
        case (r_state)
            E_IDLE: begin
                wr_en   = i_start;
                wr_addr = '0;
                wr_data = VAL_W'(1);
            end
            E_CHECK: begin
                o_look.rd = (r_rem > VAL_W'(1)) && r_rem[0];
            end
            E_DIV: begin
                div_req.start = 1'b1;
            end
            E_APP_RD: begin
                rd_en = 1'b1;
            end
            E_APP_WR: begin
                wr_en = has_room;
            end
            E_EMIT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_k[SLOT_AW-1:0];
            end
            E_EMIT: begin
                o_res_valid = 1'b1;
                o_done      = i_res_ready && is_last;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                r_rem   <= i_value;
                r_count <= CNT_W'(1);
                r_k     <= '0;
            end
            E_CHECK: begin
                r_p     <= VAL_W'(2);
                r_power <= VAL_W'(1);
                r_base  <= r_count;
                r_first <= 1'b1;
            end
            E_LOOK: begin
                r_p <= look_p;
            end
            E_DIV_WAIT: begin
                if (div_rsp.done && div_accept) begin
                    r_rem <= div_rsp.quot;
                end
            end
            E_POW: begin
                r_power <= mul_lo;
                r_i     <= '0;
            end
            E_APP_MUL: begin
                r_prod <= mul_lo;
            end
            E_APP_WR: begin
                r_i <= i_inc;
                if (has_room) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            E_AFTER: begin
                r_first <= 1'b0;
            end
            E_EMIT: begin
                if (i_res_ready) begin
                    r_k <= r_k + CNT_W'(1);
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule

// ----- sim/spf_sieve_divisor_enumerator_checker.sv -----
module spf_sieve_divisor_enumerator_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  spf_pkg::t_in_word         i_in_word,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  spf_pkg::t_out_word        i_out_word,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [spf_pkg::VAL_W-1:0] i_cfg_data,
    output int                        o_pending,
    output int                        o_fail_count
);
    import spf_pkg::*;

    localparam int REPORT_MAX = 40;

    logic [VAL_W-1:0] limit_q;
    bit               built_q;
    logic [FAC_W-1:0] factor_tbl [TBL_DEPTH];
    t_out_word        due_divisors [$];
    int               fails;

    function automatic int eff_limit();
        return (limit_q < MAX_VALUE) ? int'(limit_q) : MAX_VALUE;
    endfunction

    function automatic void sieve_table_rebuild();
        int lim;
        int p;
        int m;
        lim = eff_limit();
        foreach (factor_tbl[i]) factor_tbl[i] = '0;
        for (p = 3; p * p <= lim; p += 2) begin
            if (factor_tbl[p >> 1] == '0) begin
                for (m = p * p; m <= lim; m += 2 * p) begin
                    if (factor_tbl[m >> 1] == '0)
                        factor_tbl[m >> 1] = FAC_W'(p);
                end
            end
        end
        built_q = 1'b1;
    endfunction

    function automatic int smallest_factor_of(int v);
        int f;
        if (v % 2 == 0)
            return 2;
        f = factor_tbl[(v >> 1) % TBL_DEPTH];
        return (f < 2) ? v : f;
    endfunction

    function automatic void queue_divisors(int value);
        int        dl [SLOTS];
        int        cnt;
        int        rem;
        int        p;
        int        base;
        int        pw;
        t_out_word w;
        cnt   = 1;
        rem   = value;
        dl[0] = 1;
        while (rem > 1) begin
            p = smallest_factor_of(rem);
            if (p < 2)
                p = rem;
            base = cnt;
            pw   = 1;
            do begin
                rem = rem / p;
                pw  = pw * p;
                for (int i = 0; i < base; i++) begin
                    if (cnt < SLOTS) begin
                        dl[cnt] = (dl[i] * pw) & ((1 << VAL_W) - 1);
                        cnt++;
                    end
                end
            end while (rem > 1 && rem % p == 0);
        end
        for (int k = 0; k < cnt; k++) begin
            w.divisor = VAL_W'(dl[k]);
            w.last    = (k == cnt - 1);
            w.error   = 1'b0;
            due_divisors.insert(due_divisors.size(), w);
        end
    endfunction

    function automatic void enumerate_for_word(t_in_word w);
        t_out_word r;
        r.divisor = '0;
        r.last    = 1'b1;
        r.error   = 1'b0;
        if (w.opcode == OP_BUILD) begin
            sieve_table_rebuild();
            due_divisors.insert(due_divisors.size(), r);
        end else if (!built_q || w.query_value == '0
                     || int'(w.query_value) > eff_limit()) begin
            r.error = 1'b1;
            due_divisors.insert(due_divisors.size(), r);
        end else begin
            queue_divisors(int'(w.query_value));
        end
    endfunction

    function automatic void report_word(bit have_want, t_out_word want, t_out_word got);
        fails++;
        if (fails <= REPORT_MAX) begin
            if (have_want)
                $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d (divisor/last/error)",
                         $time, want.divisor, want.last, want.error,
                         got.divisor, got.last, got.error);
            else
                $display("%0t: expected none, got %0d/%0d/%0d (divisor/last/error)",
                         $time, got.divisor, got.last, got.error);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            limit_q = VAL_W'(MAX_VALUE);
            built_q = 1'b0;
            fails   = 0;
            due_divisors.delete();
            foreach (factor_tbl[i]) factor_tbl[i] = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                limit_q = i_cfg_data;
                built_q = 1'b0;
            end
            if (i_in_valid && i_in_ready)
                enumerate_for_word(i_in_word);
            if (i_out_valid && i_out_ready) begin
                if (due_divisors.size() == 0) begin
                    report_word(1'b0, '0, i_out_word);
                end else begin
                    want = due_divisors.pop_front();
                    if (want.divisor !== i_out_word.divisor || want.last !== i_out_word.last ||
                        want.error !== i_out_word.error)
                        report_word(1'b1, want, i_out_word);
                end
            end
        end
        o_pending    <= due_divisors.size();
        o_fail_count <= fails;
    end

endmodule

// ----- sim/spf_sieve_divisor_enumerator_core_test.sv -----
module spf_sieve_divisor_enumerator_core_test;
    import spf_pkg::*;

    localparam int QUIET_LIMIT = 200000;
    localparam int HOLD_AFTER  = 100;
    localparam int LONG_HOLD   = 500;
    localparam int TAIL_CYCLES = 50;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_in_word         i_in_word   = '0;
    logic             i_out_ready = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [VAL_W-1:0] i_cfg_data  = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out_word        o_out_word;
    logic             o_cfg_ready;
    int               pending;
    int               fail_count;
    bit               idle_on = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    spf_sieve_divisor_enumerator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    spf_sieve_divisor_enumerator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    task automatic send_word(input logic op, input int val);
        t_in_word w;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        w.opcode      = op;
        w.query_value = VAL_W'(val);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_limit(input int lim);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= VAL_W'(lim);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_query(int lim);
        int rich [8] = '{7560, 5040, 6720, 2520, 720, 360, 4096, 1024};
        int sel;
        int pick;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        if (sel <= 2)
            return $urandom_range(0, MAX_VALUE);
        if (sel <= 4 && lim < MAX_VALUE)
            return $urandom_range(lim + 1, MAX_VALUE);
        if (sel <= 6) begin
            pick = rich[$urandom_range(0, 7)];
            if (pick <= lim)
                return pick;
        end
        if (sel == 7)
            return lim;
        return $urandom_range(1, lim);
    endfunction

    // receiver: short random stalls (while idle_on is set) plus one long hold-off to back up the input
    initial begin : result_sink
        int taken;
        int gap;
        bit held;
        taken = 0;
        gap   = 0;
        held  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                taken++;
            if (gap > 0) begin
                gap--;
            end else if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = LONG_HOLD;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 3);
            end
            i_out_ready <= (gap == 0);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int lim;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit, nothing built yet
        send_word(OP_QUERY, 5);
        send_word(OP_QUERY, 0);
        send_word(OP_BUILD, $urandom);
        send_word(OP_QUERY, 1);
        send_word(OP_QUERY, 2);
        send_word(OP_QUERY, MAX_VALUE);
        send_word(OP_QUERY, 0);
        send_word(OP_QUERY, 4096);
        send_word(OP_QUERY, 5040);
        send_word(OP_QUERY, 7560);
        send_word(OP_QUERY, 7921);
        send_word(OP_QUERY, 961);

        write_limit(2);
        send_word(OP_BUILD, 0);
        send_word(OP_QUERY, 1);
        send_word(OP_QUERY, 2);
        send_word(OP_QUERY, 3);
        send_word(OP_QUERY, MAX_VALUE);

        // limit below two
        write_limit(1);
        send_word(OP_QUERY, 1);
        send_word(OP_BUILD, MAX_VALUE);
        send_word(OP_QUERY, 1);
        send_word(OP_QUERY, 2);

        write_limit(0);
        send_word(OP_BUILD, 0);
        send_word(OP_QUERY, 1);

        // limit change drops the table
        write_limit(100);
        send_word(OP_QUERY, 50);
        send_word(OP_BUILD, 0);
        send_word(OP_QUERY, 97);
        send_word(OP_QUERY, 99);
        send_word(OP_QUERY, 100);
        send_word(OP_QUERY, 101);
        send_word(OP_QUERY, 64);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6)
                idle_on <= 1'b0;
            if (ph == 6)
                lim = MAX_VALUE;
            else if (ph == 3)
                lim = $urandom_range(2000, MAX_VALUE - 1);
            else
                lim = $urandom_range(2, 1500);
            write_limit(lim);
            if ($urandom_range(0, 2) == 0)
                send_word(OP_QUERY, $urandom_range(1, MAX_VALUE));
            send_word(OP_BUILD, $urandom);
            repeat (16) begin
                if ($urandom_range(0, 30) == 0)
                    send_word(OP_BUILD, $urandom);
                else
                    send_word(OP_QUERY, pick_query(lim));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
